// ===== rtl/core/lmls_pkg.sv =====
// Package for the LCD mode and scanline sequencer.
// Mode codes, line timing constants and shared types; no dependencies.
`default_nettype none

package lmls_pkg;

    localparam int unsigned VISIBLE_LINES_DEF = 144;
    localparam int unsigned TOTAL_LINES_DEF   = 154;

    localparam int unsigned CYCLES_W  = 8;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned LINE_W    = 8;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 16'hFFFF;
    localparam logic [ELAPSED_W-1:0] LEN_HBLANK   = 16'd204;
    localparam logic [ELAPSED_W-1:0] LEN_VLINE    = 16'd456;
    localparam logic [ELAPSED_W-1:0] LEN_SEARCH   = 16'd80;
    localparam logic [ELAPSED_W-1:0] LEN_TRANSFER = 16'd172;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        lcd_mode_t            mode;
        logic [LINE_W-1:0]    line;
    } seq_state_t;

    typedef struct packed {
        logic vblank_request;
        logic render_request;
    } seq_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcd_mode_line_sequencer_top.sv =====
// Top level of the LCD mode and scanline sequencer.
// Depends on lmls_pkg and lmls_step.
//
// Usage:
//   s_tdata[7:0] carries each word's unsigned CPU time step, added to elapsed.
//   Each accepted input word yields exactly one output word on m_tdata:
//   [1:0] lcd_mode, [9:2] line, [10] vblank_request, [11] render_request.
//   cfg_wr_en/cfg_wr_data[0] write lcd_enable; write only while idle.
//   Path: an accepted word passes through the input register, then the
//   result register, to m_tvalid; it moves on when the output is free.
//   Throughput: one word per clock while m_tready is high; the mode/line/
//   elapsed state updates as a word moves from the input register to the
//   output register, so back-to-back words never wait on each other.
//   Stall: while m_tready is low, the result holds and one more word may
//   sit in the input register; s_tready drops only when both are full.
//   Reset: state returns to h-blank, line 0, elapsed 0, lcd_enable 1;
//   both registers empty.
`default_nettype none

module lcd_mode_line_sequencer_top #(
    parameter int unsigned VISIBLE_LINES = lmls_pkg::VISIBLE_LINES_DEF,
    parameter int unsigned TOTAL_LINES   = lmls_pkg::TOTAL_LINES_DEF
) (
    input  wire  logic                            clk,
    input  wire  logic                            rst_n,
    input  wire  logic                            s_tvalid,
    output logic                                  s_tready,
    input  wire  logic [lmls_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] cycles
    output logic                                  m_tvalid,
    input  wire  logic                            m_tready,
    output logic [lmls_pkg::OUT_DATA_W-1:0]       m_tdata,   // [1:0] lcd_mode, [9:2] line,
                                                             // [10] vblank_request,
                                                             // [11] render_request
    input  wire  logic                            cfg_wr_en,
    input  wire  logic [0:0]                      cfg_wr_data // [0] lcd_enable
);
    import lmls_pkg::*;

    logic                 in_valid_reg;
    logic [CYCLES_W-1:0]  in_cycles_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                 lcd_enable_reg;
    seq_state_t           state_reg;
    seq_state_t           state_next;
    seq_flags_t           flags;
    logic                 advance;
    logic                 s_accept;

    lmls_step #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_step (
        .cycles     (in_cycles_reg),
        .lcd_enable (lcd_enable_reg),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .flags      (flags)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lcd_enable_reg <= 1'b1;
            state_reg      <= '{elapsed: '0, mode: MODE_HBLANK, line: '0};
        end
        else
        begin
            if (cfg_wr_en)
                lcd_enable_reg <= cfg_wr_data[0];
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_cycles_reg <= s_tdata[CYCLES_W-1:0];
        if (advance)
            out_data_reg <= {4'b0000, flags.render_request, flags.vblank_request,
                             state_next.line, state_next.mode};
    end

    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[1:0] == MODE_VBLANK))
        else $error("vblank request without v-blank mode");

    a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[11]) |->
            (m_tdata[1:0] == MODE_SEARCH || m_tdata[1:0] == MODE_VBLANK))
        else $error("render request outside a line end");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without backpressure");

endmodule

`default_nettype wire

// ===== rtl/core/lmls_step.sv =====
// Next-state logic of the LCD mode sequencer: at most one mode transition per word.
// Depends on lmls_pkg.
`default_nettype none

module lmls_step #(
    parameter int unsigned VISIBLE_LINES = lmls_pkg::VISIBLE_LINES_DEF,
    parameter int unsigned TOTAL_LINES   = lmls_pkg::TOTAL_LINES_DEF
) (
    input  wire  logic [lmls_pkg::CYCLES_W-1:0] cycles,
    input  wire  logic                          lcd_enable,
    input  wire  lmls_pkg::seq_state_t          state_cur,
    output lmls_pkg::seq_state_t                state_nxt,
    output lmls_pkg::seq_flags_t                flags
);
    import lmls_pkg::*;

    localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] TOT_LINE = LINE_W'(TOTAL_LINES);

    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] el_sat;
    logic [LINE_W-1:0]    line_inc;

    always_comb
    begin
        sum      = {1'b0, state_cur.elapsed} + {{(ELAPSED_W+1-CYCLES_W){1'b0}}, cycles};
        el_sat   = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
        line_inc = state_cur.line + 8'd1;

        state_nxt.elapsed    = el_sat;
        state_nxt.mode       = state_cur.mode;
        state_nxt.line       = state_cur.line;
        flags.vblank_request = 1'b0;
        flags.render_request = 1'b0;

        case (state_cur.mode)
            MODE_HBLANK:
            begin
                if (el_sat >= LEN_HBLANK)
                begin
                    state_nxt.elapsed = el_sat - LEN_HBLANK;
                    if (lcd_enable)
                    begin
                        flags.render_request = (state_cur.line < VIS_LINE);
                        state_nxt.line       = line_inc;
                        if (line_inc >= VIS_LINE)
                        begin
                            flags.vblank_request = 1'b1;
                            state_nxt.mode       = MODE_VBLANK;
                        end
                        else
                        begin
                            state_nxt.mode = MODE_SEARCH;
                        end
                    end
                end
            end
            MODE_VBLANK:
            begin
                if (lcd_enable && (el_sat >= LEN_VLINE))
                begin
                    state_nxt.elapsed = el_sat - LEN_VLINE;
                    state_nxt.line    = line_inc;
                    if (line_inc == TOT_LINE)
                    begin
                        state_nxt.line = '0;
                        state_nxt.mode = MODE_SEARCH;
                    end
                end
            end
            MODE_SEARCH:
            begin
                if (el_sat >= LEN_SEARCH)
                begin
                    state_nxt.elapsed = el_sat - LEN_SEARCH;
                    state_nxt.mode    = MODE_TRANSFER;
                end
            end
            MODE_TRANSFER:
            begin
                if (el_sat >= LEN_TRANSFER)
                begin
                    state_nxt.elapsed = el_sat - LEN_TRANSFER;
                    state_nxt.mode    = MODE_HBLANK;
                end
            end
            default:
            begin
                state_nxt.mode = MODE_HBLANK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/tb_lcd_mode_line_sequencer_top.sv =====
// Testbench for lcd_mode_line_sequencer_top: streams cycle-count words, predicts mode,
// line and request flags per word and checks each result word in order.
// Depends on lmls_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_lcd_mode_line_sequencer_top;

    import lmls_pkg::*;

    localparam int unsigned VIS_LINES   = VISIBLE_LINES_DEF;
    localparam int unsigned ALL_LINES   = TOTAL_LINES_DEF;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct {
        lcd_mode_t         lcd_mode;
        logic [LINE_W-1:0] line;
        logic              vblank_request;
        logic              render_request;
    } line_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_wr_data = 1'b0;

    logic [CYCLES_W-1:0] cycles_q[$];
    line_status_t        status_q[$];

    logic [ELAPSED_W-1:0] elapsed_cnt = '0;
    lcd_mode_t            cur_mode = MODE_HBLANK;
    logic [LINE_W-1:0]    cur_line = '0;
    logic                 lcd_on = 1'b1;

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned quiet_cycles = 0;

    int errors = 0;
    int n_words = 0;
    int n_checked = 0;
    int n_vblank = 0;
    int n_render = 0;
    int n_saturated = 0;

    lcd_mode_line_sequencer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic line_status_t advance_timing(input logic [CYCLES_W-1:0] cyc);
        logic [ELAPSED_W:0] sum;
        line_status_t       r;
        sum = {1'b0, elapsed_cnt} + {{(ELAPSED_W+1-CYCLES_W){1'b0}}, cyc};
        if (sum[ELAPSED_W])
        begin
            elapsed_cnt = ELAPSED_MAX;
            n_saturated++;
        end
        else
        begin
            elapsed_cnt = sum[ELAPSED_W-1:0];
        end
        r.vblank_request = 1'b0;
        r.render_request = 1'b0;
        case (cur_mode)
            MODE_HBLANK:
            begin
                if (elapsed_cnt >= LEN_HBLANK)
                begin
                    elapsed_cnt = elapsed_cnt - LEN_HBLANK;
                    if (lcd_on)
                    begin
                        if (cur_line < VIS_LINES)
                            r.render_request = 1'b1;
                        cur_line = cur_line + 8'd1;
                        if (cur_line >= VIS_LINES)
                        begin
                            r.vblank_request = 1'b1;
                            cur_mode = MODE_VBLANK;
                        end
                        else
                        begin
                            cur_mode = MODE_SEARCH;
                        end
                    end
                end
            end
            MODE_VBLANK:
            begin
                if (lcd_on && elapsed_cnt >= LEN_VLINE)
                begin
                    elapsed_cnt = elapsed_cnt - LEN_VLINE;
                    cur_line = cur_line + 8'd1;
                    if (cur_line == ALL_LINES)
                    begin
                        cur_line = '0;
                        cur_mode = MODE_SEARCH;
                    end
                end
            end
            MODE_SEARCH:
            begin
                if (elapsed_cnt >= LEN_SEARCH)
                begin
                    elapsed_cnt = elapsed_cnt - LEN_SEARCH;
                    cur_mode = MODE_TRANSFER;
                end
            end
            default:
            begin
                if (elapsed_cnt >= LEN_TRANSFER)
                begin
                    elapsed_cnt = elapsed_cnt - LEN_TRANSFER;
                    cur_mode = MODE_HBLANK;
                end
            end
        endcase
        r.lcd_mode = cur_mode;
        r.line = cur_line;
        return r;
    endfunction

    function automatic logic [CYCLES_W-1:0] pick_cycles();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return CYCLES_W'($urandom_range(15));
        else if (roll < 70)
            return CYCLES_W'($urandom_range(255, 180));
        else
            return CYCLES_W'($urandom_range(255));
    endfunction

    // Offer the next word; hold it until accepted.
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (cycles_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= cycles_q.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            status_q.push_back(advance_timing(s_tdata));
            n_words++;
        end
    end

    // Stall the output at random; hold it off for a long stretch on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        line_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = status_q.pop_front();
                n_checked++;
                if (want.vblank_request)
                    n_vblank++;
                if (want.render_request)
                    n_render++;
                if (m_tdata[1:0] !== want.lcd_mode)
                begin
                    errors++;
                    $display("%0t: lcd_mode mismatch, expected %0d, actual %0d",
                             $time, want.lcd_mode, m_tdata[1:0]);
                end
                if (m_tdata[9:2] !== want.line)
                begin
                    errors++;
                    $display("%0t: line mismatch, expected %0d, actual %0d",
                             $time, want.line, m_tdata[9:2]);
                end
                if (m_tdata[10] !== want.vblank_request)
                begin
                    errors++;
                    $display("%0t: vblank_request mismatch, expected %b, actual %b",
                             $time, want.vblank_request, m_tdata[10]);
                end
                if (m_tdata[11] !== want.render_request)
                begin
                    errors++;
                    $display("%0t: render_request mismatch, expected %b, actual %b",
                             $time, want.render_request, m_tdata[11]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        do
            @(negedge clk);
        while (cycles_q.size() != 0 || s_tvalid || status_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_lcd_enable(input logic value);
        wait_drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        lcd_on = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_pace(input int unsigned src_pct, input int unsigned snk_pct);
        @(negedge clk);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    task automatic queue_random(input int n);
        @(negedge clk);
        repeat (n) cycles_q.push_back(pick_cycles());
    endtask

    task automatic queue_range(input int n, input int unsigned lo, input int unsigned hi);
        @(negedge clk);
        repeat (n) cycles_q.push_back(CYCLES_W'($urandom_range(hi, lo)));
    endtask

    initial
    begin
        logic [CYCLES_W-1:0] directed[$];
        directed = '{8'd0, 8'd203, 8'd1, 8'd79, 8'd1, 8'd171, 8'd1, 8'd204, 8'd80, 8'd172,
                     8'd255, 8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'h55, 8'hAA};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Exact mode thresholds and bit patterns from reset.
        write_lcd_enable(1'b1);
        set_pace(0, 0);
        @(negedge clk);
        foreach (directed[i])
            cycles_q.push_back(directed[i]);

        // Sparse sender, with a full pause halfway.
        set_pace(77, 0);
        queue_random(50);
        wait_drain();
        queue_random(50);

        // Slow receiver and one long hold-off while the sender keeps offering.
        wait_drain();
        set_pace(0, 77);
        queue_random(100);
        @(posedge clk);
        hold_toggle <= ~hold_toggle;

        // Run into v-blank, then freeze it with the display off until elapsed saturates.
        set_pace(32, 32);
        wait_drain();
        while (cur_mode != MODE_VBLANK)
        begin
            queue_range(8, 180, 255);
            wait_drain();
        end
        write_lcd_enable(1'b0);
        queue_range(270, 250, 255);
        write_lcd_enable(1'b1);
        set_pace(0, 0);
        queue_random(60);

        // Display off in h-blank: h-blank repeats.
        wait_drain();
        while (cur_mode != MODE_HBLANK)
        begin
            queue_range(1, 0, 255);
            wait_drain();
        end
        write_lcd_enable(1'b0);
        set_pace(77, 0);
        queue_random(40);
        write_lcd_enable(1'b1);
        set_pace(32, 32);
        queue_random(50);

        wait_drain();
        repeat (10) @(posedge clk);
        if (status_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, status_q.size());
        end
        $display("Checked %0d result words for %0d input words: %0d v-blank entries, %0d lines",
                 n_checked, n_words, n_vblank, n_render);
        $display("Covered display-off h-blank and v-blank, %0d saturating steps, long stalls",
                 n_saturated);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lmls_pkg.sv
rtl/core/lmls_step.sv
rtl/core/lcd_mode_line_sequencer_top.sv
sim/tb_lcd_mode_line_sequencer_top.sv
